// ----- hdl/eatr_pkg.sv -----
package eatr_pkg;

    localparam int AXIS_BITS     = 2;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // axis codes; the three of them always add up to AXIS_SUM
    localparam logic [AXIS_BITS-1:0] AXIS_X   = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_Y   = 2'd1;
    localparam logic [AXIS_BITS-1:0] AXIS_Z   = 2'd2;
    localparam logic [AXIS_BITS-1:0] AXIS_SUM = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [APB_ADDR_BITS-3:0] REG_FIRST_AXIS  = 2'd0;
    localparam logic [APB_ADDR_BITS-3:0] REG_SECOND_AXIS = 2'd1;
    localparam logic [APB_ADDR_BITS-3:0] REG_THIRD_AXIS  = 2'd2;

    // place of an axis in the configured sequence
    typedef enum logic [1:0] {
        ROLE_I,
        ROLE_J,
        ROLE_T
    } role_t;

    // matrix entry in sequence coordinates, row role * 3 + column role
    typedef enum logic [3:0] {
        SLOT_II,
        SLOT_IJ,
        SLOT_IT,
        SLOT_JI,
        SLOT_JJ,
        SLOT_JT,
        SLOT_TI,
        SLOT_TJ,
        SLOT_TT
    } slot_t;

    typedef struct packed {
        logic            bad;
        logic            euler;
        logic            sg_neg;
        role_t [2:0]     role;
    } ctl_t;

    localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
    localparam int          TAYLOR_TERMS = 14;
    localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    function automatic slot_t slot_of(input role_t rr, input role_t rc);
        return slot_t'(4'(rr) * 4'd3 + 4'(rc));
    endfunction

    // (a*b) >> 62, kept to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(2^frac_bits * sin(2*pi*n / 2^angle_bits)) by a Q62 Taylor series;
    // evaluated at elaboration only
    function automatic int unsigned sine_entry(input int unsigned n,
                                               input int unsigned angle_bits,
                                               input int unsigned frac_bits);
        int unsigned s;
        logic [63:0] low_mask;
        logic [63:0] nn;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] t;
        s        = angle_bits - 2;
        low_mask = (64'd1 << s) - 64'd1;
        nn       = 64'(n);
        x        = (HALF_PI_Q62 >> s) * nn + (((HALF_PI_Q62 & low_mask) * nn) >> s);
        x2       = mul_q62(x, x);
        term     = x;
        sum      = x;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = mul_q62(term, x2) / TAYLOR_DIV[k];
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        t = sum >> (62 - frac_bits - 1);
        return 32'((t + 64'd1) >> 1);
    endfunction

endpackage

// ----- hdl/eatr_if.sv -----
interface eatr_angle_if #(parameter int ANGLE_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] first_angle;
    logic [ANGLE_BITS-1:0] second_angle;
    logic [ANGLE_BITS-1:0] third_angle;

    modport source (output valid, output first_angle, output second_angle,
                    output third_angle, input ready);
    modport sink   (input valid, input first_angle, input second_angle,
                    input third_angle, output ready);
endinterface

interface eatr_matrix_if #(parameter int FRAC_BITS = 14);
    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS+1:0] r_xx;
    logic signed [FRAC_BITS+1:0] r_xy;
    logic signed [FRAC_BITS+1:0] r_xz;
    logic signed [FRAC_BITS+1:0] r_yx;
    logic signed [FRAC_BITS+1:0] r_yy;
    logic signed [FRAC_BITS+1:0] r_yz;
    logic signed [FRAC_BITS+1:0] r_zx;
    logic signed [FRAC_BITS+1:0] r_zy;
    logic signed [FRAC_BITS+1:0] r_zz;
    logic                        axis_error;

    modport source (output valid, output r_xx, output r_xy, output r_xz,
                    output r_yx, output r_yy, output r_yz, output r_zx,
                    output r_zy, output r_zz, output axis_error, input ready);
    modport sink   (input valid, input r_xx, input r_xy, input r_xz,
                    input r_yx, input r_yy, input r_yz, input r_zx,
                    input r_zy, input r_zz, input axis_error, output ready);
endinterface

// ----- hdl/euler_angles_to_rotation.sv -----
// Euler/Cardan angles to 3x3 rotation matrix. Each item carries three binary angles
// (2^ANGLE_BITS = full turn); the axis sequence comes from three APB registers at
// byte addresses 0, 4 and 8 (0 = x, 1 = y, 2 = z; third equal to first selects the
// Euler form). Entries are signed with FRAC_BITS fraction bits and saturate to +-1.0;
// an illegal sequence returns a zero matrix with axis_error set. The datapath is a
// six-stage pipeline: sine/cosine table read, quadrant sign, first products, chained
// product, sum and saturate, output register. One item is taken every cycle as long
// as the sink keeps up, and its matrix passes through the stages in that order; each
// stage holds its item on a stall and bubbles close up behind it. The quarter-wave
// table has 2^(ANGLE_BITS-2)+1 entries and is held three times, once per angle, each
// copy read for sine and cosine in the same cycle.
module euler_angles_to_rotation import eatr_pkg::*;
#(
    parameter int ANGLE_BITS = 12,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    eatr_angle_if.sink               angles,
    eatr_matrix_if.source            matrix
);

    localparam int A  = ANGLE_BITS;
    localparam int W  = FRAC_BITS + 2;
    localparam logic [A-1:0] QuarterAngle = A'(1) << (A - 2);
    localparam logic [A-2:0] QuarterIndex = (A-1)'(1) << (A - 2);
    localparam logic signed [W-1:0] One  = W'(1) << FRAC_BITS;
    localparam logic signed [W-1:0] Zero = '0;

    ctl_t                ctl;
    ctl_t                ctl1_reg;
    ctl_t                ctl2_reg;
    logic [5:3]          bad_reg;
    logic [6:1]          vld_reg;
    logic [6:1]          en;

    logic [A-1:0]        ang [3];
    logic [A-1:0]        cos_ang [3];
    logic [FRAC_BITS:0]  sin_mag [3];
    logic [FRAC_BITS:0]  cos_mag [3];
    logic                sin_neg1_reg [3];
    logic                cos_neg1_reg [3];
    logic signed [W-1:0] sin2_reg [3];
    logic signed [W-1:0] cos2_reg [3];

    logic signed [W-1:0] sa, ca, sb, cb, sc, cc;
    logic signed [W-1:0] psa, nsa, msa, pca, nca, ncb, psb;

    logic signed [W-1:0] op_a [9];
    logic signed [W-1:0] op_b [9];
    logic signed [W-1:0] op_c [9];
    logic signed [W-1:0] op_d [9];
    logic signed [W-1:0] op_e [9];
    logic                op_neg [9];
    logic signed [W-1:0] slot [9];
    logic signed [W-1:0] m_reg [9];
    logic                err_reg;

    eatr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctl     (ctl)
    );

    // each stage advances when empty or when the one after it advances
    always_comb
    begin
        en[6] = !vld_reg[6] || matrix.ready;
        for (int k = 5; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign angles.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[1])
                vld_reg[1] <= angles.valid;
            for (int k = 2; k <= 6; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    function automatic logic [A-2:0] rom_index(input logic [A-1:0] angle);
        return angle[A-2] ? QuarterIndex - {1'b0, angle[A-3:0]} : {1'b0, angle[A-3:0]};
    endfunction

    assign ang[0] = angles.first_angle;
    assign ang[1] = angles.second_angle;
    assign ang[2] = angles.third_angle;

    // table read and quadrant sign, one copy per angle
    for (genvar g = 0; g < 3; g++)
    begin : g_trig
        assign cos_ang[g] = ang[g] + QuarterAngle;

        eatr_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_rom
        (
            .clk       (clk),
            .en        (en[1]),
            .sin_index (rom_index(ang[g])),
            .cos_index (rom_index(cos_ang[g])),
            .sin_mag   (sin_mag[g]),
            .cos_mag   (cos_mag[g])
        );

        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                sin_neg1_reg[g] <= ang[g][A-1];
                cos_neg1_reg[g] <= cos_ang[g][A-1];
            end
            if (en[2])
            begin
                sin2_reg[g] <= sin_neg1_reg[g] ? -$signed({1'b0, sin_mag[g]})
                                               : $signed({1'b0, sin_mag[g]});
                cos2_reg[g] <= cos_neg1_reg[g] ? -$signed({1'b0, cos_mag[g]})
                                               : $signed({1'b0, cos_mag[g]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            ctl1_reg <= ctl;
        if (en[2])
            ctl2_reg <= ctl1_reg;
        if (en[3])
            bad_reg[3] <= ctl2_reg.bad;
        if (en[4])
            bad_reg[4] <= bad_reg[3];
        if (en[5])
            bad_reg[5] <= bad_reg[4];
    end

    assign sa = sin2_reg[0];
    assign ca = cos2_reg[0];
    assign sb = sin2_reg[1];
    assign cb = cos2_reg[1];
    assign sc = sin2_reg[2];
    assign cc = cos2_reg[2];

    // sequence sign folded into the operands
    assign psa = ctl2_reg.sg_neg ? -sa : sa;
    assign nsa = ctl2_reg.sg_neg ? sa : -sa;
    assign msa = -sa;
    assign pca = ctl2_reg.sg_neg ? -ca : ca;
    assign nca = ctl2_reg.sg_neg ? ca : -ca;
    assign ncb = ctl2_reg.sg_neg ? cb : -cb;
    assign psb = ctl2_reg.sg_neg ? -sb : sb;

    // one lane per output entry; each lane works out sat(a*b*c + d*e), then negates it when op_neg is set
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int Lane = r * 3 + c;
            slot_t code;

            assign code = slot_of(ctl2_reg.role[r], ctl2_reg.role[c]);

            always_comb
            begin
                op_a[Lane]   = Zero;
                op_b[Lane]   = Zero;
                op_c[Lane]   = One;
                op_d[Lane]   = Zero;
                op_e[Lane]   = Zero;
                op_neg[Lane] = 1'b0;
                if (!ctl2_reg.euler)
                begin
                    case (code)
                        SLOT_II: begin op_a[Lane] = cb;  op_b[Lane] = cc; end
                        SLOT_IJ: begin op_a[Lane] = ncb; op_b[Lane] = sc; end
                        SLOT_IT: begin op_a[Lane] = psb; op_b[Lane] = One; end
                        SLOT_JI:
                        begin
                            op_a[Lane] = sa;  op_b[Lane] = sb; op_c[Lane] = cc;
                            op_d[Lane] = pca; op_e[Lane] = sc;
                        end
                        SLOT_JJ:
                        begin
                            op_a[Lane] = nsa; op_b[Lane] = sb; op_c[Lane] = sc;
                            op_d[Lane] = cc;  op_e[Lane] = ca;
                        end
                        SLOT_JT: begin op_a[Lane] = nsa; op_b[Lane] = cb; end
                        SLOT_TI:
                        begin
                            op_a[Lane] = nca; op_b[Lane] = sb; op_c[Lane] = cc;
                            op_d[Lane] = sa;  op_e[Lane] = sc;
                        end
                        SLOT_TJ:
                        begin
                            op_a[Lane] = ca;  op_b[Lane] = sb; op_c[Lane] = sc;
                            op_d[Lane] = psa; op_e[Lane] = cc;
                        end
                        SLOT_TT: begin op_a[Lane] = ca; op_b[Lane] = cb; end
                        default: ;
                    endcase
                end
                else
                begin
                    case (code)
                        SLOT_II: begin op_a[Lane] = cb;  op_b[Lane] = One; end
                        SLOT_IJ: begin op_a[Lane] = sb;  op_b[Lane] = sc; end
                        SLOT_IT: begin op_a[Lane] = psb; op_b[Lane] = cc; end
                        SLOT_JI: begin op_a[Lane] = sa;  op_b[Lane] = sb; end
                        SLOT_JJ:
                        begin
                            op_a[Lane] = msa; op_b[Lane] = cb; op_c[Lane] = sc;
                            op_d[Lane] = ca;  op_e[Lane] = cc;
                        end
                        SLOT_JT:
                        begin
                            op_a[Lane] = sa;  op_b[Lane] = cb; op_c[Lane] = cc;
                            op_d[Lane] = ca;  op_e[Lane] = sc;
                            op_neg[Lane] = !ctl2_reg.sg_neg;
                        end
                        SLOT_TI: begin op_a[Lane] = nca; op_b[Lane] = sb; end
                        SLOT_TJ:
                        begin
                            op_a[Lane] = ca;  op_b[Lane] = cb; op_c[Lane] = sc;
                            op_d[Lane] = sa;  op_e[Lane] = cc;
                            op_neg[Lane] = ctl2_reg.sg_neg;
                        end
                        SLOT_TT:
                        begin
                            op_a[Lane] = ca;  op_b[Lane] = cb; op_c[Lane] = cc;
                            op_d[Lane] = msa; op_e[Lane] = sc;
                        end
                        default: ;
                    endcase
                end
            end

            eatr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane
            (
                .clk      (clk),
                .en_prod  (en[3]),
                .en_chain (en[4]),
                .en_sum   (en[5]),
                .a        (op_a[Lane]),
                .b        (op_b[Lane]),
                .c        (op_c[Lane]),
                .d        (op_d[Lane]),
                .e        (op_e[Lane]),
                .negate   (op_neg[Lane]),
                .slot     (slot[Lane])
            );

            always_ff @(posedge clk)
            begin
                if (en[6])
                    m_reg[Lane] <= bad_reg[5] ? Zero : slot[Lane];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
            err_reg <= bad_reg[5];
    end

    assign matrix.valid      = vld_reg[6];
    assign matrix.r_xx       = m_reg[0];
    assign matrix.r_xy       = m_reg[1];
    assign matrix.r_xz       = m_reg[2];
    assign matrix.r_yx       = m_reg[3];
    assign matrix.r_yy       = m_reg[4];
    assign matrix.r_yz       = m_reg[5];
    assign matrix.r_zx       = m_reg[6];
    assign matrix.r_zy       = m_reg[7];
    assign matrix.r_zz       = m_reg[8];
    assign matrix.axis_error = err_reg;

endmodule

// ----- hdl/eatr_cfg.sv -----
module eatr_cfg import eatr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output ctl_t                     ctl
);

    logic [AXIS_BITS-1:0]     first_axis_reg;
    logic [AXIS_BITS-1:0]     second_axis_reg;
    logic [AXIS_BITS-1:0]     third_axis_reg;
    logic [APB_ADDR_BITS-3:0] reg_index;
    logic                     wr;
    logic [AXIS_BITS-1:0]     t_axis;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_BITS-1:2];
    assign wr        = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_axis_reg  <= AXIS_X;
            second_axis_reg <= AXIS_Y;
            third_axis_reg  <= AXIS_Z;
        end
        else if (wr)
        begin
            case (reg_index)
                REG_FIRST_AXIS:  first_axis_reg  <= pwdata[AXIS_BITS-1:0];
                REG_SECOND_AXIS: second_axis_reg <= pwdata[AXIS_BITS-1:0];
                REG_THIRD_AXIS:  third_axis_reg  <= pwdata[AXIS_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FIRST_AXIS:  prdata = APB_DATA_BITS'(first_axis_reg);
            REG_SECOND_AXIS: prdata = APB_DATA_BITS'(second_axis_reg);
            REG_THIRD_AXIS:  prdata = APB_DATA_BITS'(third_axis_reg);
            default:         prdata = '0;
        endcase
    end

    function automatic role_t role_of(input logic [AXIS_BITS-1:0] axis,
                                      input logic [AXIS_BITS-1:0] i,
                                      input logic [AXIS_BITS-1:0] j);
        if (axis == i)
            return ROLE_I;
        if (axis == j)
            return ROLE_J;
        return ROLE_T;
    endfunction

    // Euler sequences repeat the first axis; the third role goes to the axis left over
    assign t_axis = (first_axis_reg == third_axis_reg)
                  ? AXIS_SUM - first_axis_reg - second_axis_reg
                  : third_axis_reg;

    always_comb
    begin
        ctl.bad    = (first_axis_reg == AXIS_SUM) || (second_axis_reg == AXIS_SUM)
                  || (third_axis_reg == AXIS_SUM) || (first_axis_reg == second_axis_reg)
                  || (second_axis_reg == third_axis_reg);
        ctl.euler  = (first_axis_reg == third_axis_reg);
        ctl.sg_neg = !((first_axis_reg == AXIS_X && second_axis_reg == AXIS_Y)
                    || (first_axis_reg == AXIS_Y && second_axis_reg == AXIS_Z)
                    || (first_axis_reg == AXIS_Z && second_axis_reg == AXIS_X));
        ctl.role[AXIS_X] = role_of(AXIS_X, first_axis_reg, second_axis_reg);
        ctl.role[AXIS_Y] = role_of(AXIS_Y, first_axis_reg, second_axis_reg);
        ctl.role[AXIS_Z] = role_of(AXIS_Z, first_axis_reg, second_axis_reg);
        if (t_axis == AXIS_SUM)
            ctl.euler = 1'b0;
    end

endmodule

// ----- hdl/eatr_sine_rom.sv -----
module eatr_sine_rom import eatr_pkg::*;
#(
    parameter int ANGLE_BITS = 12,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-2:0] sin_index,
    input  logic [ANGLE_BITS-2:0] cos_index,
    output logic [FRAC_BITS:0]    sin_mag,
    output logic [FRAC_BITS:0]    cos_mag
);

    localparam int Depth = (1 << (ANGLE_BITS - 2)) + 1;

    logic [FRAC_BITS:0] rom [Depth];
    logic [FRAC_BITS:0] sin_mag_reg;
    logic [FRAC_BITS:0] cos_mag_reg;

    for (genvar n = 0; n < Depth; n++)
    begin : g_rom
        assign rom[n] = (FRAC_BITS+1)'(sine_entry(n, ANGLE_BITS, FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= rom[sin_index];
            cos_mag_reg <= rom[cos_index];
        end
    end

    assign sin_mag = sin_mag_reg;
    assign cos_mag = cos_mag_reg;

endmodule

// ----- hdl/eatr_lane.sv -----
module eatr_lane import eatr_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic                        clk,
    input  logic                        en_prod,
    input  logic                        en_chain,
    input  logic                        en_sum,
    input  logic signed [FRAC_BITS+1:0] a,
    input  logic signed [FRAC_BITS+1:0] b,
    input  logic signed [FRAC_BITS+1:0] c,
    input  logic signed [FRAC_BITS+1:0] d,
    input  logic signed [FRAC_BITS+1:0] e,
    input  logic                        negate,
    output logic signed [FRAC_BITS+1:0] slot
);

    localparam int W = FRAC_BITS + 2;
    localparam logic signed [2*W-1:0] Half    = (2*W)'(1) << (FRAC_BITS - 1);
    localparam logic signed [W:0]     OneWide = (W+1)'(1) << FRAC_BITS;

    logic signed [W-1:0] ab_reg;
    logic signed [W-1:0] de_reg;
    logic signed [W-1:0] c_reg;
    logic                neg3_reg;
    logic signed [W-1:0] abc_reg;
    logic signed [W-1:0] de4_reg;
    logic                neg4_reg;
    logic signed [W-1:0] slot_reg;
    logic signed [W-1:0] slot_next;
    logic signed [W:0]   sum;
    logic signed [W:0]   sum_sat;

    // product rounded half up: floor((x*y + half) / 2^FRAC_BITS)
    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic signed [2*W-1:0] p;
        p = (2*W)'(x) * (2*W)'(y) + Half;
        return W'(p >>> FRAC_BITS);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            ab_reg   <= fmul(a, b);
            de_reg   <= fmul(d, e);
            c_reg    <= c;
            neg3_reg <= negate;
        end
        if (en_chain)
        begin
            abc_reg  <= fmul(ab_reg, c_reg);
            de4_reg  <= de_reg;
            neg4_reg <= neg3_reg;
        end
        if (en_sum)
            slot_reg <= slot_next;
    end

    always_comb
    begin
        sum = (W+1)'(abc_reg) + (W+1)'(de4_reg);
        if (sum > OneWide)
            sum_sat = OneWide;
        else if (sum < -OneWide)
            sum_sat = -OneWide;
        else
            sum_sat = sum;
        slot_next = neg4_reg ? W'(-sum_sat) : W'(sum_sat);
    end

    assign slot = slot_reg;

endmodule

// ----- hdl/eatr_checker.sv -----
module eatr_checker import eatr_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [APB_ADDR_BITS-1:0]    paddr,
    input logic [APB_DATA_BITS-1:0]    pwdata,
    input logic [APB_DATA_BITS-1:0]    prdata,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic signed [FRAC_BITS+1:0] r_xx,
    input logic signed [FRAC_BITS+1:0] r_xy,
    input logic signed [FRAC_BITS+1:0] r_xz,
    input logic signed [FRAC_BITS+1:0] r_yx,
    input logic signed [FRAC_BITS+1:0] r_yy,
    input logic signed [FRAC_BITS+1:0] r_yz,
    input logic signed [FRAC_BITS+1:0] r_zx,
    input logic signed [FRAC_BITS+1:0] r_zy,
    input logic signed [FRAC_BITS+1:0] r_zz,
    input logic                        axis_error
);

    localparam int W = FRAC_BITS + 2;
    localparam logic signed [W-1:0] One = W'(1) << FRAC_BITS;

    function automatic logic in_range(input logic signed [W-1:0] x);
        return (x <= One) && (x >= -One);
    endfunction

    // a stalled item holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(r_xx) && $stable(r_xy)
            && $stable(r_xz) && $stable(r_yx) && $stable(r_yy) && $stable(r_yz)
            && $stable(r_zx) && $stable(r_zy) && $stable(r_zz) && $stable(axis_error))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && axis_error |-> r_xx == '0 && r_xy == '0 && r_xz == '0
            && r_yx == '0 && r_yy == '0 && r_yz == '0 && r_zx == '0 && r_zy == '0
            && r_zz == '0)
        else $error("matrix not cleared on illegal axis sequence");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !axis_error |-> in_range(r_xx) && in_range(r_xy) && in_range(r_xz)
            && in_range(r_yx) && in_range(r_yy) && in_range(r_yz) && in_range(r_zx)
            && in_range(r_zy) && in_range(r_zz))
        else $error("matrix entry beyond unity");

    // a register read straight after a write to it returns the low bits written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && $past(psel && penable && pwrite) && paddr == $past(paddr)
            && (paddr[APB_ADDR_BITS-1:2] == REG_FIRST_AXIS
                || paddr[APB_ADDR_BITS-1:2] == REG_SECOND_AXIS
                || paddr[APB_ADDR_BITS-1:2] == REG_THIRD_AXIS)
        |-> prdata == APB_DATA_BITS'($past(pwdata[AXIS_BITS-1:0])))
        else $error("axis register read back wrong");

endmodule

bind euler_angles_to_rotation eatr_checker #(.FRAC_BITS(FRAC_BITS)) u_eatr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .res_valid  (matrix.valid),
    .res_ready  (matrix.ready),
    .r_xx       (matrix.r_xx),
    .r_xy       (matrix.r_xy),
    .r_xz       (matrix.r_xz),
    .r_yx       (matrix.r_yx),
    .r_yy       (matrix.r_yy),
    .r_yz       (matrix.r_yz),
    .r_zx       (matrix.r_zx),
    .r_zy       (matrix.r_zy),
    .r_zz       (matrix.r_zz),
    .axis_error (matrix.axis_error)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import eatr_pkg::*;

    localparam int ANGLE_W    = 12;
    localparam int FRAC_W     = 14;
    localparam int QUARTER    = 1 << (ANGLE_W - 2);
    localparam longint ONE_Q  = 64'sd1 << FRAC_W;
    localparam int STALL_CAP  = 4000;
    localparam int DRAIN_WAIT = 12;
    localparam int N_PHASES   = 14;
    localparam int N_DIRECTED = 24;

    // axis code that names no axis at all
    localparam logic [AXIS_BITS-1:0] AXIS_NONE = 2'd3;
    // address slot past the last register
    localparam logic [APB_ADDR_BITS-3:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_IDENTITY,
        EXP_AXIS_ERROR
    } exp_kind_t;

    typedef struct packed {
        logic             err;
        logic [8:0][15:0] m;      // row-major, index 0 is r_xx
    } rot_t;

    typedef struct packed {
        logic [AXIS_BITS-1:0] ax_i;
        logic [AXIS_BITS-1:0] ax_j;
        logic [AXIS_BITS-1:0] ax_k;
        logic [ANGLE_W-1:0]   ang0;
        logic [ANGLE_W-1:0]   ang1;
        logic [ANGLE_W-1:0]   ang2;
        exp_kind_t            kind;
    } stim_row_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{AXIS_X, AXIS_Y, AXIS_Z, 12'd0,    12'd0,    12'd0,    EXP_IDENTITY},
        '{AXIS_X, AXIS_Y, AXIS_Z, 12'd4095, 12'd4095, 12'd4095, EXP_PREDICT},
        '{AXIS_X, AXIS_Y, AXIS_Z, 12'd1024, 12'd0,    12'd0,    EXP_PREDICT},
        '{AXIS_X, AXIS_Y, AXIS_Z, 12'd0,    12'd1024, 12'd0,    EXP_PREDICT},
        '{AXIS_X, AXIS_Y, AXIS_Z, 12'd0,    12'd0,    12'd1024, EXP_PREDICT},
        '{AXIS_X, AXIS_Y, AXIS_Z, 12'd2048, 12'd2048, 12'd2048, EXP_PREDICT},
        '{AXIS_X, AXIS_Y, AXIS_Z, 12'd3072, 12'd1024, 12'd512,  EXP_PREDICT},
        '{AXIS_X, AXIS_Z, AXIS_Y, 12'd512,  12'd512,  12'd512,  EXP_PREDICT},
        '{AXIS_Y, AXIS_Z, AXIS_X, 12'd1000, 12'd3000, 12'd2047, EXP_PREDICT},
        '{AXIS_Y, AXIS_X, AXIS_Z, 12'd2049, 12'd1023, 12'd3071, EXP_PREDICT},
        '{AXIS_Z, AXIS_X, AXIS_Y, 12'd4095, 12'd0,    12'd4095, EXP_PREDICT},
        '{AXIS_Z, AXIS_Y, AXIS_X, 12'd512,  12'd1536, 12'd2560, EXP_PREDICT},
        '{AXIS_X, AXIS_Y, AXIS_X, 12'd0,    12'd0,    12'd0,    EXP_IDENTITY},
        '{AXIS_X, AXIS_Z, AXIS_X, 12'd1024, 12'd2048, 12'd3072, EXP_PREDICT},
        '{AXIS_Y, AXIS_X, AXIS_Y, 12'd4095, 12'd4095, 12'd4095, EXP_PREDICT},
        '{AXIS_Y, AXIS_Z, AXIS_Y, 12'd512,  12'd1024, 12'd1536, EXP_PREDICT},
        '{AXIS_Z, AXIS_X, AXIS_Z, 12'd3000, 12'd100,  12'd2000, EXP_PREDICT},
        '{AXIS_Z, AXIS_Y, AXIS_Z, 12'd2048, 12'd1024, 12'd0,    EXP_PREDICT},
        '{AXIS_X, AXIS_X, AXIS_Z, 12'd4095, 12'd4095, 12'd4095, EXP_AXIS_ERROR},
        '{AXIS_X, AXIS_Y, AXIS_Y, 12'd1234, 12'd2345, 12'd3456, EXP_AXIS_ERROR},
        '{AXIS_NONE, AXIS_Y, AXIS_Z, 12'd0, 12'd0,    12'd0,    EXP_AXIS_ERROR},
        '{AXIS_X, AXIS_NONE, AXIS_Z, 12'd1, 12'd2,    12'd3,    EXP_AXIS_ERROR},
        '{AXIS_X, AXIS_Y, AXIS_NONE, 12'd4095, 12'd0, 12'd4095, EXP_AXIS_ERROR},
        '{AXIS_Z, AXIS_Z, AXIS_Z, 12'd100,  12'd200,  12'd300,  EXP_AXIS_ERROR}
    };

    string field_name [0:8] = '{"r_xx", "r_xy", "r_xz", "r_yx", "r_yy", "r_yz",
                                "r_zx", "r_zy", "r_zz"};

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    eatr_angle_if  #(.ANGLE_BITS(ANGLE_W)) angles_if ();
    eatr_matrix_if #(.FRAC_BITS(FRAC_W))   matrix_if ();

    euler_angles_to_rotation #(
        .ANGLE_BITS(ANGLE_W),
        .FRAC_BITS (FRAC_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .angles (angles_if),
        .matrix (matrix_if)
    );

    longint               sine_tab [0:QUARTER];
    logic [AXIS_BITS-1:0] axis_cfg [0:2];
    rot_t                 pending_matrices [$];
    exp_kind_t            item_kind;
    bit                   src_gaps;
    bit                   sink_stalls;
    int                   mismatches;
    int                   items_sent;
    int                   matrices_checked;
    int                   settings_used;
    int                   idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint sine_at(input logic [ANGLE_W-1:0] a);
        logic [1:0]         quad;
        logic [ANGLE_W-3:0] r;
        longint             v;
        quad = a[ANGLE_W-1:ANGLE_W-2];
        r    = a[ANGLE_W-3:0];
        v    = quad[0] ? sine_tab[QUARTER - int'(r)] : sine_tab[r];
        return quad[1] ? -v : v;
    endfunction

    // product rounded half up, floor shift
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (ONE_Q >>> 1)) >>> FRAC_W;
    endfunction

    function automatic longint clamp_one(input longint v);
        if (v > ONE_Q)
            return ONE_Q;
        if (v < -ONE_Q)
            return -ONE_Q;
        return v;
    endfunction

    function automatic rot_t predict_rotation(input logic [ANGLE_W-1:0] a0,
                                              input logic [ANGLE_W-1:0] a1,
                                              input logic [ANGLE_W-1:0] a2);
        longint m [3][3];
        longint sa, ca, sb, cb, sc, cc, sg;
        int     i, j, k, l;
        rot_t   res;
        res = '0;
        i   = axis_cfg[0];
        j   = axis_cfg[1];
        k   = axis_cfg[2];
        if (i > 2 || j > 2 || k > 2 || i == j || j == k)
        begin
            res.err = 1'b1;
            return res;
        end
        sa = sine_at(a0);
        ca = sine_at(ANGLE_W'(a0 + QUARTER));
        sb = sine_at(a1);
        cb = sine_at(ANGLE_W'(a1 + QUARTER));
        sc = sine_at(a2);
        cc = sine_at(ANGLE_W'(a2 + QUARTER));
        sg = ((j + 3 - i) % 3 == 1) ? 1 : -1;
        if (i != k)
        begin
            // Cardan sequence
            m[i][i] = qmul(cb, cc);
            m[i][j] = qmul(-sg * cb, sc);
            m[i][k] = sg * sb;
            m[j][i] = clamp_one(qmul(qmul(sa, sb), cc) + qmul(sg * ca, sc));
            m[j][j] = clamp_one(qmul(qmul(-sg * sa, sb), sc) + qmul(cc, ca));
            m[j][k] = qmul(-sg * sa, cb);
            m[k][i] = clamp_one(qmul(qmul(-sg * ca, sb), cc) + qmul(sa, sc));
            m[k][j] = clamp_one(qmul(qmul(ca, sb), sc) + qmul(sg * sa, cc));
            m[k][k] = qmul(ca, cb);
        end
        else
        begin
            // Euler sequence, l is the axis left out
            l = 3 - i - j;
            m[i][i] = cb;
            m[i][j] = qmul(sb, sc);
            m[i][l] = qmul(sg * sb, cc);
            m[j][i] = qmul(sa, sb);
            m[j][j] = clamp_one(qmul(qmul(-sa, cb), sc) + qmul(ca, cc));
            m[j][l] = -sg * clamp_one(qmul(ca, sc) + qmul(qmul(sa, cb), cc));
            m[l][i] = qmul(-sg * ca, sb);
            m[l][j] = sg * clamp_one(qmul(qmul(ca, cb), sc) + qmul(sa, cc));
            m[l][l] = clamp_one(qmul(-sa, sc) + qmul(qmul(ca, cb), cc));
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                res.m[r * 3 + c] = 16'(m[r][c]);
        return res;
    endfunction

    function automatic rot_t typed_matrix(input exp_kind_t kind);
        rot_t res;
        res = '0;
        if (kind == EXP_IDENTITY)
        begin
            res.m[0] = 16'(ONE_Q);
            res.m[4] = 16'(ONE_Q);
            res.m[8] = 16'(ONE_Q);
        end
        else
            res.err = 1'b1;
        return res;
    endfunction

    function automatic rot_t grab_output();
        rot_t res;
        res.m[0] = matrix_if.r_xx;
        res.m[1] = matrix_if.r_xy;
        res.m[2] = matrix_if.r_xz;
        res.m[3] = matrix_if.r_yx;
        res.m[4] = matrix_if.r_yy;
        res.m[5] = matrix_if.r_yz;
        res.m[6] = matrix_if.r_zx;
        res.m[7] = matrix_if.r_zy;
        res.m[8] = matrix_if.r_zz;
        res.err  = matrix_if.axis_error;
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("tb_top: mismatch on %s at %0t: expected %0d, got %0d",
                     what, $realtime, want, got);
    endtask

    always @(posedge clk)
    begin : scoreboard
        rot_t got;
        rot_t want;
        if (angles_if.valid === 1'b1 && angles_if.ready === 1'b1)
        begin
            if (item_kind == EXP_PREDICT)
                want = predict_rotation(angles_if.first_angle, angles_if.second_angle,
                                        angles_if.third_angle);
            else
                want = typed_matrix(item_kind);
            pending_matrices.push_back(want);
            items_sent++;
        end
        if (matrix_if.valid === 1'b1 && matrix_if.ready === 1'b1)
        begin
            got = grab_output();
            matrices_checked++;
            if (pending_matrices.size() == 0)
                note_mismatch("matrix with none pending", 0, 0);
            else
            begin
                want = pending_matrices.pop_front();
                for (int f = 0; f < 9; f++)
                    if (got.m[f] !== want.m[f])
                        note_mismatch(field_name[f], $signed(want.m[f]), $signed(got.m[f]));
                if (got.err !== want.err)
                    note_mismatch("axis_error", want.err, got.err);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((angles_if.valid && angles_if.ready) || (matrix_if.valid && matrix_if.ready)
            || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_CAP)
        begin
            $display("tb_top: run stuck for %0d cycles", idle_cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // mostly short, now and then long
    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    initial
    begin
        int hold;
        hold = 0;
        matrix_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                matrix_if.ready <= 1'b0;
                hold--;
            end
            else if (sink_stalls && $urandom_range(0, 99) < 25)
            begin
                matrix_if.ready <= 1'b0;
                hold = pick_span() - 1;
            end
            else
                matrix_if.ready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [APB_ADDR_BITS-3:0] idx,
                             input logic [APB_DATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx <= REG_THIRD_AXIS)
            axis_cfg[idx] = data[AXIS_BITS-1:0];
    endtask

    task automatic apb_check_read(input logic [APB_ADDR_BITS-3:0] idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== APB_DATA_BITS'(axis_cfg[idx]))
            note_mismatch("register read", axis_cfg[idx], prdata);
    endtask

    // drop valid, drain, then rewrite the whole axis sequence and read it back
    task automatic set_axes(input logic [AXIS_BITS-1:0] ax_i,
                            input logic [AXIS_BITS-1:0] ax_j,
                            input logic [AXIS_BITS-1:0] ax_k);
        @(negedge clk);
        angles_if.valid <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        apb_write(REG_FIRST_AXIS,  {30'($urandom), ax_i});
        apb_write(REG_SECOND_AXIS, {30'($urandom), ax_j});
        apb_write(REG_THIRD_AXIS,  {30'($urandom), ax_k});
        if ($urandom_range(0, 1) == 1)
            apb_write(REG_SPARE, $urandom);
        apb_check_read(REG_FIRST_AXIS);
        apb_check_read(REG_SECOND_AXIS);
        apb_check_read(REG_THIRD_AXIS);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    task automatic send_angles(input logic [ANGLE_W-1:0] a0, input logic [ANGLE_W-1:0] a1,
                               input logic [ANGLE_W-1:0] a2, input exp_kind_t kind);
        int gap;
        gap = (src_gaps && $urandom_range(0, 99) < 30) ? pick_span() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            angles_if.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        angles_if.valid        <= 1'b1;
        angles_if.first_angle  <= a0;
        angles_if.second_angle <= a1;
        angles_if.third_angle  <= a2;
        item_kind              <= kind;
        do
            @(posedge clk);
        while (angles_if.ready !== 1'b1);
    endtask

    // random angles, now and then from quarter-turn neighbourhoods, including both ends of the range
    function automatic logic [ANGLE_W-1:0] pick_angle();
        if ($urandom_range(0, 9) < 3)
            return ANGLE_W'($urandom_range(0, 3) * QUARTER + $urandom_range(0, 2) - 1);
        return ANGLE_W'($urandom);
    endfunction

    initial
    begin
        int                   n_items;
        logic [AXIS_BITS-1:0] ai, aj, ak;
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        angles_if.valid        = 1'b0;
        angles_if.first_angle  = '0;
        angles_if.second_angle = '0;
        angles_if.third_angle  = '0;
        item_kind              = EXP_PREDICT;
        src_gaps               = 1'b1;
        sink_stalls            = 1'b1;
        mismatches             = 0;
        items_sent             = 0;
        matrices_checked       = 0;
        settings_used          = 1;
        idle_cycles            = 0;
        axis_cfg[0]            = AXIS_X;
        axis_cfg[1]            = AXIS_Y;
        axis_cfg[2]            = AXIS_Z;
        for (int n = 0; n <= QUARTER; n++)
            sine_tab[n] = $rtoi($floor(real'(ONE_Q)
                          * $sin(2.0 * 3.14159265358979323846 * n / (4.0 * QUARTER)) + 0.5));

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r])
        begin
            if ({DIRECTED[r].ax_i, DIRECTED[r].ax_j, DIRECTED[r].ax_k}
                != {axis_cfg[0], axis_cfg[1], axis_cfg[2]})
                set_axes(DIRECTED[r].ax_i, DIRECTED[r].ax_j, DIRECTED[r].ax_k);
            send_angles(DIRECTED[r].ang0, DIRECTED[r].ang1, DIRECTED[r].ang2,
                        DIRECTED[r].kind);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                // legal sequence, Cardan or Euler
                ai = 2'($urandom_range(0, 2));
                aj = 2'((ai + $urandom_range(1, 2)) % 3);
                ak = ($urandom_range(0, 1) == 1) ? ai : 2'(3 - ai - aj);
            end
            else
            begin
                ai = 2'($urandom_range(0, 3));
                aj = 2'($urandom_range(0, 3));
                ak = 2'($urandom_range(0, 3));
            end
            set_axes(ai, aj, ak);
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            n_items     = $urandom_range(80, 120);
            repeat (n_items)
                send_angles(pick_angle(), pick_angle(), pick_angle(), EXP_PREDICT);
        end

        @(negedge clk);
        angles_if.valid <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (pending_matrices.size() != 0)
            note_mismatch("matrices never delivered", 0, pending_matrices.size());

        $display("tb_top: %0d angle items over %0d axis settings, %0d matrices checked",
                 items_sent, settings_used, matrices_checked);
        $display("tb_top: %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/eatr_pkg.sv
hdl/eatr_if.sv
hdl/eatr_cfg.sv
hdl/eatr_sine_rom.sv
hdl/eatr_lane.sv
hdl/euler_angles_to_rotation.sv
hdl/eatr_checker.sv
dv/tb_top.sv
